### hw/rtl/assert_macros.svh
// assertion macros used by edge_min_heap.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define EMH_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never hold outside reset
`define EMH_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `EMH_ASSERT(label, clk, rstn, !(cond), msg)

`endif

### hw/rtl/emh_pkg.sv
// types and codes shared by the edge min-heap files
// no dependencies
`default_nettype none

package emh_pkg;

    localparam int CNT_W   = 9;
    localparam int LIMIT_W = 9;
    localparam int KEY_W   = 16;

    typedef struct packed {
        logic [KEY_W-1:0] va;
        logic [KEY_W-1:0] vb;
        logic [KEY_W-1:0] w;
    } entry_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef struct packed {
        status_t          status;
        entry_t           ent;
        logic [CNT_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/edge_min_heap.sv
// edge min-heap top level: stream ports, limit register, result register
// depends on emh_pkg, emh_ctrl, emh_ram and assert_macros.svh
`default_nettype none

// Priority queue of graph edges keyed by an unsigned 16-bit weight, held as a
// binary min-heap in a single-port-read memory of CAPACITY entries. Each input
// item is an insert (tuser 0) or a delete-min (tuser 1) and gives one result
// item with status, the removed edge and the entry count. One item at a time
// is worked on: an insert lets the new entry climb level by level, and a
// delete-min moves the last entry to the root and sinks it level by level;
// an insert into an empty heap, a refused insert and a delete on an empty
// heap skip these steps. The pace is set by the one read port of the heap
// memory and the one weight comparator. The next item is accepted while a
// result still waits on the output. Memory contents need no clearing after
// reset; the count alone defines the heap. The limit register may only be
// written while the block is idle.

module edge_min_heap #(
    parameter int CAPACITY = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vertex_a[15:0], vertex_b[31:16], edge_weight[47:32]
    input  wire logic [47:0] s_tdata,
    // op[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // min_vertex_a[15:0], min_vertex_b[31:16], min_weight[47:32],
    // entry_count[56:48], zero[63:57]
    output logic [63:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);
    import emh_pkg::*;

    `include "assert_macros.svh"

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_data_reg, m_data_next;
    logic               out_free;
    logic               ctrl_idle;
    logic               res_done;
    result_t            res;
    entry_t             in_entry;

    assign in_entry.va = s_tdata[15:0];
    assign in_entry.vb = s_tdata[31:16];
    assign in_entry.w  = s_tdata[47:32];

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = ctrl_idle;
    assign cfg_ready = 1'b1;

    emh_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && s_tready),
        .op       (op_t'(s_tuser[0])),
        .in_entry (in_entry),
        .limit    (limit_reg),
        .out_free (out_free),
        .idle     (ctrl_idle),
        .done     (res_done),
        .result   (res)
    );

    always_comb begin
        limit_next   = limit_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end
        if (res_done) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_W'(256);
            m_valid_reg <= 1'b0;
        end else begin
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.status;
    assign m_tdata  = {7'b0, m_data_reg.count, m_data_reg.ent.w,
                       m_data_reg.ent.vb, m_data_reg.ent.va};

    `EMH_ASSERT_NEVER(a_ready_while_done, aclk, aresetn,
        s_tready && res_done, "ready during result")
    `EMH_ASSERT(a_result_loaded, aclk, aresetn,
        res_done |=> m_tvalid, "result not loaded")
    `EMH_ASSERT(a_empty_count, aclk, aresetn,
        res_done && (res.status == ST_EMPTY) |-> (res.count == '0), "empty with count")
    `EMH_ASSERT(a_no_edge, aclk, aresetn,
        res_done && (res.status != ST_DONE) |-> (res.ent == '0), "edge on refusal")

endmodule

`default_nettype wire

### hw/rtl/emh_ram.sv
// heap entry store: one write port, one read port with registered data
// depends on emh_pkg
`default_nettype none

module emh_ram #(
    parameter int DEPTH = 257,
    parameter int AW    = 9
) (
    input  wire logic            aclk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire emh_pkg::entry_t wr_data,
    input  wire logic [AW-1:0]   rd_addr,
    output emh_pkg::entry_t      rd_data
);
    import emh_pkg::*;

    entry_t store_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/emh_ctrl.sv
// heap sequencer: sift-up and sift-down over the entry store with one comparator
// depends on emh_pkg and emh_ram
`default_nettype none

module emh_ctrl #(
    parameter int CAPACITY = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire emh_pkg::op_t                  op,
    input  wire emh_pkg::entry_t               in_entry,
    input  wire logic [emh_pkg::LIMIT_W-1:0]   limit,
    input  wire logic                          out_free,
    output logic                               idle,
    output logic                               done,
    output emh_pkg::result_t                   result
);
    import emh_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > LIMIT_W) ? CW : LIMIT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_ROOT, S_LAST, S_LEFT, S_RIGHT, S_MOVE, S_PUT, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   cpos_reg, cpos_next;
    entry_t          item_reg, item_next;
    entry_t          child_reg, child_next;
    entry_t          min_reg, min_next;
    status_t         status_reg, status_next;

    logic            mem_we;
    logic [CW-1:0]   mem_waddr;
    entry_t          mem_wdata;
    logic [CW-1:0]   mem_raddr;
    entry_t          mem_rdata;

    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             gt;
    logic             full;
    logic [CW:0]      pos2;
    logic [CW-1:0]    dpos;
    logic [CW:0]      dpos2;
    logic             desc_ok;
    logic [CW-1:0]    ppos;

    emh_ram #(
        .DEPTH (CAPACITY + 1),
        .AW    (CW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // shared comparator
    always_comb begin
        cmp_a = item_reg.w;
        cmp_b = child_reg.w;
        case (state_reg)
            S_UP: begin
                cmp_a = mem_rdata.w;
                cmp_b = item_reg.w;
            end
            S_RIGHT: begin
                cmp_a = child_reg.w;
                cmp_b = mem_rdata.w;
            end
            default: begin
                cmp_a = item_reg.w;
                cmp_b = child_reg.w;
            end
        endcase
    end

    assign gt   = cmp_a > cmp_b;
    assign full = (count_reg >= CW'(CAPACITY)) || (WW'(count_reg) >= WW'(limit));
    assign pos2 = {pos_reg, 1'b0};
    assign dpos = (state_reg == S_MOVE) ? cpos_reg : CW'(1);
    assign dpos2 = {dpos, 1'b0};
    assign desc_ok = dpos2 <= {1'b0, count_reg};
    assign ppos = pos_reg >> 1;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        cpos_next   = cpos_reg;
        item_next   = item_reg;
        child_next  = child_reg;
        min_next    = min_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = item_reg;
        mem_raddr   = '0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    item_next   = in_entry;
                    min_next    = '0;
                    status_next = ST_DONE;
                    if (op == OP_INSERT) begin
                        if (full) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            count_next = count_reg + CW'(1);
                            pos_next   = count_reg + CW'(1);
                            if (count_reg == '0) begin
                                mem_we     = 1'b1;
                                mem_waddr  = CW'(1);
                                mem_wdata  = in_entry;
                                state_next = S_DONE;
                            end else begin
                                mem_raddr  = (count_reg + CW'(1)) >> 1;
                                state_next = S_UP;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            mem_raddr  = CW'(1);
                            state_next = S_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                mem_we = 1'b1;
                if (gt) begin
                    mem_wdata = mem_rdata;
                    pos_next  = ppos;
                    if (ppos == CW'(1)) begin
                        state_next = S_PUT;
                    end else begin
                        mem_raddr = ppos >> 1;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_ROOT: begin
                min_next   = mem_rdata;
                mem_raddr  = count_reg;
                count_next = count_reg - CW'(1);
                state_next = S_LAST;
            end
            S_LAST: begin
                item_next = mem_rdata;
                pos_next  = CW'(1);
                if (count_reg == '0) begin
                    state_next = S_DONE;
                end else if (desc_ok) begin
                    mem_raddr  = dpos2[CW-1:0];
                    state_next = S_LEFT;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_LEFT: begin
                child_next = mem_rdata;
                cpos_next  = pos2[CW-1:0];
                if (pos2 < {1'b0, count_reg}) begin
                    mem_raddr  = pos2[CW-1:0] + CW'(1);
                    state_next = S_RIGHT;
                end else begin
                    state_next = S_MOVE;
                end
            end
            S_RIGHT: begin
                if (gt) begin
                    child_next = mem_rdata;
                    cpos_next  = cpos_reg + CW'(1);
                end
                state_next = S_MOVE;
            end
            S_MOVE: begin
                mem_we = 1'b1;
                if (gt) begin
                    mem_wdata = child_reg;
                    pos_next  = cpos_reg;
                    if (desc_ok) begin
                        mem_raddr  = dpos2[CW-1:0];
                        state_next = S_LEFT;
                    end else begin
                        state_next = S_PUT;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PUT: begin
                mem_we     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg    <= pos_next;
        cpos_reg   <= cpos_next;
        item_reg   <= item_next;
        child_reg  <= child_next;
        min_reg    <= min_next;
        status_reg <= status_next;
    end

    assign idle          = state_reg == S_IDLE;
    assign done          = (state_reg == S_DONE) && out_free;
    assign result.status = status_reg;
    assign result.ent    = min_reg;
    assign result.count  = CNT_W'(count_reg);

endmodule

`default_nettype wire
